/* rtl/swcf_pkg.sv */
// shared types, codes and the crc function of the sensor word framer
package swcf_pkg;

  // input modes (carried on tuser)
  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_COMP  = 2'd1;
  localparam logic [1:0] MODE_REPLY = 2'd2;

  // result kinds (carried on tuser)
  localparam logic [1:0] KIND_TX    = 2'd0;
  localparam logic [1:0] KIND_RX    = 2'd1;
  localparam logic [1:0] KIND_RANGE = 2'd2;

  // reply byte position inside a word
  localparam logic [1:0] RX_POS_FIRST  = 2'd0;
  localparam logic [1:0] RX_POS_SECOND = 2'd1;
  localparam logic [1:0] RX_POS_CRC    = 2'd2;

  localparam logic [2:0] WORD_COUNT_MAX = 3'd7;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // compensation limits in hundredths
  localparam logic signed [15:0] T_MIN = -16'sd4500;
  localparam logic signed [15:0] T_MAX = 16'sd13000;
  localparam logic signed [15:0] H_MIN = 16'sd0;
  localparam logic signed [15:0] H_MAX = 16'sd10000;

  // tick conversion: (x * 65535 + round) / span
  localparam logic [30:0] T_ROUND = 31'd8750;
  localparam logic [30:0] H_ROUND = 31'd5000;

  // the division is a multiply by ceil(2^shift / span), exact over the numerator range
  localparam logic [31:0] T_RECIP = 32'd4021071096;  // span 17500
  localparam logic [30:0] H_RECIP = 31'd1759218605;  // span 10000
  localparam int          T_SHIFT = 46;
  localparam int          H_SHIFT = 44;

  localparam logic [2:0] PLAIN_LAST_BYTE = 3'd1;
  localparam logic [2:0] COMP_LAST_BYTE  = 3'd7;

  typedef enum logic [1:0] {
    JB_PLAIN,
    JB_COMP,
    JB_RANGE,
    JB_CHECK
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [15:0] command;
    logic [30:0] num_t;
    logic [30:0] num_h;
    logic [7:0]  rx_high;
    logic [7:0]  rx_low;
    logic [7:0]  rx_crc;
    logic [2:0]  word_index;
  } job_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [7:0]  tx_byte;
    logic [15:0] rx_word;
    logic [2:0]  word_index;
    logic        crc_ok;
    logic        last;
  } result_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_SEND
  } back_state_t;

  // crc-8 over a 16-bit word, msb first, no reflection, no final xor
  function automatic logic [7:0] crc8_word(input logic [15:0] word);
    logic [7:0] crc;
    crc = CRC_INIT;
    for (int i = 15; i >= 0; i--) begin
      if (crc[7] ^ word[i]) begin
        crc = {crc[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[6:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

/* rtl/swcf_front.sv */
// front end: accepts words, tracks reply bytes, range checks and queues jobs
module swcf_front import swcf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [1:0]         mode,
  input  logic [15:0]        command,
  input  logic signed [15:0] temperature_centi,
  input  logic signed [15:0] humidity_centi,
  input  logic [7:0]         rx_byte,
  output logic               push,
  output job_t               job
);

  logic [1:0] rx_position, rx_position_next;
  logic [7:0] rx_high, rx_high_next;
  logic [7:0] rx_low, rx_low_next;
  logic [2:0] rx_word_count, rx_word_count_next;

  logic        in_range;
  logic [15:0] t_offset;
  logic [14:0] t_x;
  logic [13:0] h_x;

  assign in_range = (temperature_centi >= T_MIN) && (temperature_centi <= T_MAX) &&
                    (humidity_centi >= H_MIN) && (humidity_centi <= H_MAX);
  assign t_offset = temperature_centi - T_MIN;
  assign t_x      = t_offset[14:0];
  assign h_x      = humidity_centi[13:0];

  always_comb begin
    rx_position_next   = rx_position;
    rx_high_next       = rx_high;
    rx_low_next        = rx_low;
    rx_word_count_next = rx_word_count;
    push               = 1'b0;

    job.kind       = JB_PLAIN;
    job.command    = command;
    // x * 65535 as (x << 16) - x
    job.num_t      = {t_x, 16'b0} - 31'(t_x) + T_ROUND;
    job.num_h      = {1'b0, h_x, 16'b0} - 31'(h_x) + H_ROUND;
    job.rx_high    = rx_high;
    job.rx_low     = rx_low;
    job.rx_crc     = rx_byte;
    job.word_index = rx_word_count;

    case (mode)
      MODE_PLAIN: begin
        push               = 1'b1;
        job.kind           = JB_PLAIN;
        rx_position_next   = RX_POS_FIRST;
        rx_word_count_next = '0;
      end
      MODE_COMP: begin
        push = 1'b1;
        if (in_range) begin
          job.kind           = JB_COMP;
          rx_position_next   = RX_POS_FIRST;
          rx_word_count_next = '0;
        end else begin
          job.kind = JB_RANGE;
        end
      end
      MODE_REPLY: begin
        case (rx_position)
          RX_POS_SECOND: begin
            rx_low_next      = rx_byte;
            rx_position_next = RX_POS_CRC;
          end
          RX_POS_CRC: begin
            push             = 1'b1;
            job.kind         = JB_CHECK;
            rx_position_next = RX_POS_FIRST;
            if (rx_word_count < WORD_COUNT_MAX) begin
              rx_word_count_next = rx_word_count + 3'd1;
            end
          end
          default: begin
            rx_high_next     = rx_byte;
            rx_position_next = RX_POS_SECOND;
          end
        endcase
      end
      default: begin
        push = 1'b0;
      end
    endcase

    if (!accept) begin
      push = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_position   <= RX_POS_FIRST;
      rx_high       <= '0;
      rx_low        <= '0;
      rx_word_count <= '0;
    end else if (accept) begin
      rx_position   <= rx_position_next;
      rx_high       <= rx_high_next;
      rx_low        <= rx_low_next;
      rx_word_count <= rx_word_count_next;
    end
  end

endmodule

/* rtl/swcf_fifo.sv */
// short job queue between front and back end
module swcf_fifo import swcf_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t din,
  input  logic pop,
  output job_t dout,
  output logic full,
  output logic empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

/* rtl/swcf_back.sv */
// back end: tick division, frame byte sequencing, reply crc check, output register
module swcf_back import swcf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    empty,
  input  job_t    job,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_item
);

  back_state_t state, state_next;

  logic        can_load;
  logic        load;
  logic        div_start;
  logic        send_start;
  logic        byte_step;
  result_t     load_item;

  logic [15:0] cmd;
  logic [2:0]  byte_cnt;
  logic [2:0]  last_byte;

  // tick quotients by reciprocal multiplication, registered in BK_DIV from the operands latched when the job is taken
  logic [30:0] num_t, num_h;
  logic [62:0] prod_t;
  logic [61:0] prod_h;
  logic [15:0] q_t, q_h;
  logic [7:0]  send_byte;

  assign can_load = !out_valid || out_ready;

  assign prod_t = {32'b0, num_t} * {31'b0, T_RECIP};
  assign prod_h = {31'b0, num_h} * {31'b0, H_RECIP};

  always_comb begin
    case (byte_cnt)
      3'd0:    send_byte = cmd[15:8];
      3'd1:    send_byte = cmd[7:0];
      3'd2:    send_byte = q_h[15:8];
      3'd3:    send_byte = q_h[7:0];
      3'd4:    send_byte = crc8_word(q_h);
      3'd5:    send_byte = q_t[15:8];
      3'd6:    send_byte = q_t[7:0];
      default: send_byte = crc8_word(q_t);
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (!empty) begin
          if (job.kind == JB_COMP) begin
            state_next = BK_DIV;
          end else if (job.kind == JB_PLAIN && can_load) begin
            state_next = BK_SEND;
          end
        end
      end
      BK_DIV: begin
        state_next = BK_SEND;
      end
      BK_SEND: begin
        if (can_load && byte_cnt == last_byte) begin
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // control and load word
  always_comb begin
    pop        = 1'b0;
    load       = 1'b0;
    div_start  = 1'b0;
    send_start = 1'b0;
    byte_step  = 1'b0;

    load_item.out_kind   = KIND_TX;
    load_item.tx_byte    = '0;
    load_item.rx_word    = '0;
    load_item.word_index = '0;
    load_item.crc_ok     = 1'b0;
    load_item.last       = 1'b0;

    case (state)
      BK_IDLE: begin
        if (!empty) begin
          case (job.kind)
            JB_COMP: begin
              pop       = 1'b1;
              div_start = 1'b1;
            end
            JB_PLAIN: begin
              if (can_load) begin
                pop               = 1'b1;
                load              = 1'b1;
                send_start        = 1'b1;
                load_item.tx_byte = job.command[15:8];
              end
            end
            JB_RANGE: begin
              if (can_load) begin
                pop                = 1'b1;
                load               = 1'b1;
                load_item.out_kind = KIND_RANGE;
                load_item.last     = 1'b1;
              end
            end
            default: begin
              if (can_load) begin
                pop                  = 1'b1;
                load                 = 1'b1;
                load_item.out_kind   = KIND_RX;
                load_item.rx_word    = {job.rx_high, job.rx_low};
                load_item.word_index = job.word_index;
                load_item.crc_ok     = crc8_word({job.rx_high, job.rx_low}) == job.rx_crc;
                load_item.last       = 1'b1;
              end
            end
          endcase
        end
      end
      BK_SEND: begin
        if (can_load) begin
          load              = 1'b1;
          byte_step         = 1'b1;
          load_item.tx_byte = send_byte;
          load_item.last    = (byte_cnt == last_byte);
        end
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= load_item;
    end
    if (div_start) begin
      cmd       <= job.command;
      num_t     <= job.num_t;
      num_h     <= job.num_h;
      byte_cnt  <= '0;
      last_byte <= COMP_LAST_BYTE;
    end else if (state == BK_DIV) begin
      q_t <= prod_t[T_SHIFT +: 16];
      q_h <= prod_h[H_SHIFT +: 16];
    end
    if (send_start) begin
      cmd       <= job.command;
      byte_cnt  <= 3'd1;
      last_byte <= PLAIN_LAST_BYTE;
    end else if (byte_step) begin
      byte_cnt <= byte_cnt + 3'd1;
    end
  end

endmodule

/* rtl/sensor_word_crc_framer.sv */
// top level of the sensor word framer with crc-8 check
//
//  port group  dir  tdata (low bit up)                              tuser     tlast
//  s_*         in   command, temperature_centi, humidity_centi,      mode      -
//                   rx_byte (56 bits)
//  m_*         out  tx_byte, rx_word, word_index, crc_ok, 4'b0       out_kind  last
//
// an input word is accepted every cycle while the job queue is not full, and checked
// results leave one per cycle while m_tready is high; plain command: two output bytes;
// compensated command: job taken, ticks registered in the multipliers, then eight bytes
// range error: one output item; partial reply bytes and mode 3 make no output
// rst is synchronous and clears the reply tracking, queue and output valid
// s_tready drops only while the job queue is full; m_tready stalls the back end alone
module sensor_word_crc_framer import swcf_pkg::*; #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // command, temperature_centi, humidity_centi, rx_byte
  input  logic [1:0]  s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // tx_byte, rx_word, word_index, crc_ok, zero pad
  output logic [1:0]  m_tuser,   // out_kind
  output logic        m_tlast
);

  logic    accept;
  logic    push;
  logic    pop;
  logic    full;
  logic    empty;
  job_t    job_in;
  job_t    job_out;
  result_t out_item;

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  swcf_front u_front (
    .clk               (clk),
    .rst               (rst),
    .accept            (accept),
    .mode              (s_tuser),
    .command           (s_tdata[15:0]),
    .temperature_centi (s_tdata[31:16]),
    .humidity_centi    (s_tdata[47:32]),
    .rx_byte           (s_tdata[55:48]),
    .push              (push),
    .job               (job_in)
  );

  swcf_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (job_in),
    .pop   (pop),
    .dout  (job_out),
    .full  (full),
    .empty (empty)
  );

  swcf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .job       (job_out),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_item  (out_item)
  );

  assign m_tdata = {4'b0, out_item.crc_ok, out_item.word_index, out_item.rx_word,
                    out_item.tx_byte};
  assign m_tuser = out_item.out_kind;
  assign m_tlast = out_item.last;

endmodule

/* dv/sensor_word_crc_framer_tb.sv */
// self-checking testbench for the sensor word crc framer
`timescale 1ns / 1ps

module sensor_word_crc_framer_tb;
  import swcf_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_WORDS = 180;
  localparam int HOLD_AT = 120;
  localparam int HOLD_CYCLES = 80;
  localparam int TAIL_CYCLES = 40;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] command;
    logic [15:0] temp_centi;
    logic [15:0] hum_centi;
    logic [7:0]  rx_byte;
    logic        drain_first;  // hold this word back until all results are in
  } in_word_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;  // command, temperature_centi, humidity_centi, rx_byte
  logic [1:0]  s_tuser = '0;  // mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;  // tx_byte, rx_word, word_index, crc_ok, zero pad
  logic [1:0]  m_tuser;  // out_kind
  logic        m_tlast;

  in_word_t stim_words[$];
  result_t  owed_results[$];
  in_word_t on_bus;

  // predicted reply tracking
  logic [1:0] rx_pos;
  logic [7:0] rx_hi;
  logic [7:0] rx_lo;
  logic [2:0] rx_count;

  int words_in = 0;
  int results_out = 0;
  int total_words = 0;
  int mismatches = 0;
  int range_errors = 0;
  int bad_crcs = 0;
  int saturated = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;
  logic rx_hold;

  sensor_word_crc_framer dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [15:0] rnd16();
    return 16'($urandom);
  endfunction

  function automatic logic [7:0] rnd8();
    return 8'($urandom);
  endfunction

  // byte-wise crc-8, poly 0x31, init 0xff
  function automatic logic [7:0] word_crc(input logic [7:0] hi, input logic [7:0] lo);
    logic [7:0] crc;
    logic [7:0] bytes [2];
    bytes[0] = hi;
    bytes[1] = lo;
    crc = 8'hFF;
    foreach (bytes[i]) begin
      crc = crc ^ bytes[i];
      repeat (8) crc = crc[7] ? ((crc << 1) ^ 8'h31) : (crc << 1);
    end
    return crc;
  endfunction

  function automatic logic [15:0] temp_ticks(input logic [15:0] t);
    longint num;
    num = (longint'($signed(t)) + 4500) * 65535 + 8750;
    return 16'(num / 17500);
  endfunction

  function automatic logic [15:0] hum_ticks(input logic [15:0] h);
    longint num;
    num = longint'($signed(h)) * 65535 + 5000;
    return 16'(num / 10000);
  endfunction

  task automatic owe_tx(input logic [7:0] b, input logic is_last);
    result_t r;
    r = '0;
    r.out_kind = KIND_TX;
    r.tx_byte = b;
    r.last = is_last;
    owed_results.push_back(r);
  endtask

  // update the predicted state for one accepted word and queue its results
  task automatic frame_and_check(input in_word_t w);
    logic [15:0] tt;
    logic [15:0] ht;
    logic [7:0]  tc;
    logic [7:0]  hc;
    result_t     r;
    r = '0;
    case (w.mode)
      MODE_PLAIN: begin
        owe_tx(w.command[15:8], 1'b0);
        owe_tx(w.command[7:0], 1'b1);
        rx_pos = RX_POS_FIRST;
        rx_count = '0;
      end
      MODE_COMP: begin
        if ($signed(w.temp_centi) < T_MIN || $signed(w.temp_centi) > T_MAX ||
            $signed(w.hum_centi) < H_MIN || $signed(w.hum_centi) > H_MAX) begin
          r.out_kind = KIND_RANGE;
          r.last = 1'b1;
          owed_results.push_back(r);
        end else begin
          tt = temp_ticks(w.temp_centi);
          ht = hum_ticks(w.hum_centi);
          tc = word_crc(tt[15:8], tt[7:0]);
          hc = word_crc(ht[15:8], ht[7:0]);
          owe_tx(w.command[15:8], 1'b0);
          owe_tx(w.command[7:0], 1'b0);
          owe_tx(ht[15:8], 1'b0);
          owe_tx(ht[7:0], 1'b0);
          owe_tx(hc, 1'b0);
          owe_tx(tt[15:8], 1'b0);
          owe_tx(tt[7:0], 1'b0);
          owe_tx(tc, 1'b1);
          rx_pos = RX_POS_FIRST;
          rx_count = '0;
        end
      end
      MODE_REPLY: begin
        case (rx_pos)
          RX_POS_SECOND: begin
            rx_lo = w.rx_byte;
            rx_pos = RX_POS_CRC;
          end
          RX_POS_CRC: begin
            r.out_kind = KIND_RX;
            r.rx_word = {rx_hi, rx_lo};
            r.word_index = rx_count;
            r.crc_ok = (word_crc(rx_hi, rx_lo) == w.rx_byte);
            r.last = 1'b1;
            owed_results.push_back(r);
            rx_pos = RX_POS_FIRST;
            if (rx_count != WORD_COUNT_MAX) rx_count = rx_count + 3'd1;
          end
          default: begin
            rx_hi = w.rx_byte;
            rx_pos = RX_POS_SECOND;
          end
        endcase
      end
      default: ;  // unused mode is dropped
    endcase
  endtask

  task automatic report_error(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input int got, input int want);
    if (got != want) report_error($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  task automatic add_word(input logic [1:0] mode, input logic [15:0] cmd,
                          input logic [15:0] t, input logic [15:0] h, input logic [7:0] b);
    in_word_t w;
    w.mode = mode;
    w.command = cmd;
    w.temp_centi = t;
    w.hum_centi = h;
    w.rx_byte = b;
    w.drain_first = 1'b0;
    stim_words.push_back(w);
  endtask

  // three reply bytes: high, low, crc (optionally corrupted in one bit)
  task automatic add_reply(input logic [15:0] data, input logic good);
    logic [7:0] crc;
    crc = word_crc(data[15:8], data[7:0]);
    if (!good) crc = crc ^ (8'h01 << $urandom_range(0, 7));
    add_word(MODE_REPLY, rnd16(), rnd16(), rnd16(), data[15:8]);
    add_word(MODE_REPLY, rnd16(), rnd16(), rnd16(), data[7:0]);
    add_word(MODE_REPLY, rnd16(), rnd16(), rnd16(), crc);
  endtask

  function automatic int idle_phase();
    return (words_in / 30) % 4;
  endfunction

  assign rx_hold = (hold_left != 0);

  // one long receiver hold-off so the job queue fills and the input stalls
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && words_in >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // driver
  always @(posedge clk) begin
    logic     sender_idle;
    logic     hold_word;
    in_word_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
      rx_pos = RX_POS_FIRST;
      rx_hi = '0;
      rx_lo = '0;
      rx_count = '0;
    end else begin
      if (s_tvalid && s_tready) begin
        frame_and_check(on_bus);
        words_in <= words_in + 1;
      end
      if (!s_tvalid || s_tready) begin
        case (idle_phase())
          1: sender_idle = ($urandom_range(0, 99) < 67);
          3: sender_idle = ($urandom_range(0, 99) < 12);
          default: sender_idle = 1'b0;
        endcase
        if (rx_hold) sender_idle = 1'b0;
        hold_word = stim_words.size() != 0 && stim_words[0].drain_first &&
                    owed_results.size() != 0;
        if (stim_words.size() != 0 && !sender_idle && !hold_word) begin
          nxt = stim_words.pop_front();
          on_bus = nxt;
          s_tvalid <= 1'b1;
          s_tdata <= {nxt.rx_byte, nxt.hum_centi, nxt.temp_centi, nxt.command};
          s_tuser <= nxt.mode;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t want;
    logic    stall;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_out <= results_out + 1;
        if (owed_results.size() == 0) begin
          report_error($sformatf("unexpected word kind %0d data 0x%0h", m_tuser, m_tdata));
        end else begin
          want = owed_results.pop_front();
          compare_field("out_kind", int'(m_tuser), int'(want.out_kind));
          compare_field("tx_byte", int'(m_tdata[7:0]), int'(want.tx_byte));
          compare_field("rx_word", int'(m_tdata[23:8]), int'(want.rx_word));
          compare_field("word_index", int'(m_tdata[26:24]), int'(want.word_index));
          compare_field("crc_ok", int'(m_tdata[27]), int'(want.crc_ok));
          compare_field("last", int'(m_tlast), int'(want.last));
          if (want.out_kind == KIND_RANGE) range_errors++;
          if (want.out_kind == KIND_RX && !want.crc_ok) bad_crcs++;
          if (want.out_kind == KIND_RX && want.word_index == WORD_COUNT_MAX) saturated++;
        end
      end
      case (idle_phase())
        2: stall = ($urandom_range(0, 99) < 67);
        3: stall = ($urandom_range(0, 99) < 12);
        default: stall = 1'b0;
      endcase
      m_tready <= !(stall || rx_hold);
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", quiet_cycles);
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int pick;
    int n;
    logic [15:0] t;
    logic [15:0] h;

    // directed: command extremes, range edges, rounding halves, reply cases
    add_word(MODE_PLAIN, 16'h0000, rnd16(), rnd16(), rnd8());
    add_word(MODE_PLAIN, 16'hFFFF, rnd16(), rnd16(), rnd8());
    add_word(MODE_COMP, 16'h2619, -16'sd4500, 16'sd0, rnd8());
    add_word(MODE_COMP, 16'hA55A, 16'sd13000, 16'sd10000, rnd8());
    add_word(MODE_COMP, 16'h5AA5, 16'sd4250, 16'sd1000, rnd8());  // exact halves
    add_word(MODE_COMP, 16'h1234, 16'sd2500, 16'sd5000, rnd8());
    add_word(MODE_COMP, 16'h1234, -16'sd4501, 16'sd5000, rnd8());
    add_word(MODE_COMP, 16'h1234, 16'sd13001, 16'sd5000, rnd8());
    add_word(MODE_COMP, 16'h1234, 16'sd2500, -16'sd1, rnd8());
    add_word(MODE_COMP, 16'h1234, 16'sd2500, 16'sd10001, rnd8());
    add_word(MODE_COMP, 16'hFFFF, 16'h8000, 16'h7FFF, rnd8());
    add_word(MODE_COMP, 16'h0000, 16'h7FFF, 16'h8000, rnd8());
    add_word(MODE_SPARE, rnd16(), rnd16(), rnd16(), rnd8());
    add_reply(16'hBEEF, 1'b1);
    add_reply(16'h0000, 1'b0);
    // partial word broken off by a command
    add_word(MODE_REPLY, rnd16(), rnd16(), rnd16(), 8'hFF);
    add_word(MODE_REPLY, rnd16(), rnd16(), rnd16(), 8'h00);
    add_word(MODE_PLAIN, 16'h8001, rnd16(), rnd16(), rnd8());
    add_reply(16'hFFFF, 1'b1);

    n = stim_words.size();
    while (stim_words.size() < n + RANDOM_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        repeat ($urandom_range(1, 10)) add_reply(rnd16(), $urandom_range(0, 3) != 0);
      end else if (pick < 45) begin
        add_word(MODE_REPLY, rnd16(), rnd16(), rnd16(), rnd8());
      end else if (pick < 60) begin
        add_word(MODE_PLAIN, rnd16(), rnd16(), rnd16(), rnd8());
      end else if (pick < 80) begin
        t = 16'($urandom_range(0, 17500) - 4500);
        h = 16'($urandom_range(0, 10000));
        add_word(MODE_COMP, rnd16(), t, h, rnd8());
      end else if (pick < 92) begin
        add_word(MODE_COMP, rnd16(), rnd16(), rnd16(), rnd8());
      end else if (pick < 97) begin
        // one step past an edge, the other value in range
        t = 16'($urandom_range(0, 17500) - 4500);
        h = 16'($urandom_range(0, 10000));
        case ($urandom_range(0, 3))
          0: t = -16'sd4501;
          1: t = 16'sd13001;
          2: h = -16'sd1;
          default: h = 16'sd10001;
        endcase
        add_word(MODE_COMP, rnd16(), t, h, rnd8());
      end else begin
        add_word(MODE_SPARE, rnd16(), rnd16(), rnd16(), rnd8());
      end
    end
    // let everything drain before these words
    stim_words[80].drain_first = 1'b1;
    stim_words[170].drain_first = 1'b1;
    total_words = stim_words.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (words_in != total_words) @(posedge clk);
    while (owed_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d input words and %0d results: %0d range errors,", words_in,
             results_out, range_errors);
    $display("%0d bad reply crcs, %0d replies at the saturated word index", bad_crcs,
             saturated);
    if (mismatches == 0 && owed_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/swcf_pkg.sv
rtl/swcf_front.sv
rtl/swcf_fifo.sv
rtl/swcf_back.sv
rtl/sensor_word_crc_framer.sv
dv/sensor_word_crc_framer_tb.sv
